// ===== rtl/jsunesc_pkg.sv =====
package jsunesc_pkg;

    // Result kinds.
    localparam logic [2:0] KIND_DATA  = 3'd0;
    localparam logic [2:0] KIND_DONE  = 3'd1;
    localparam logic [2:0] KIND_NOQ   = 3'd2;
    localparam logic [2:0] KIND_BADE  = 3'd3;
    localparam logic [2:0] KIND_BADH  = 3'd4;
    localparam logic [2:0] KIND_CTRL  = 3'd5;
    localparam logic [2:0] KIND_UNTER = 3'd6;

    // One decoded input byte yields at most one group of one to three result beats.
    typedef struct packed {
        logic [2:0][7:0] bytes;     // data bytes, beat 0 in bytes[0]
        logic [2:0]      kind;      // same kind on every beat of the group
        logic [1:0]      last_idx;  // index of the final beat
    } grp_t;

endpackage

// ===== rtl/jsunesc_decode.sv =====
module jsunesc_decode import jsunesc_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic [7:0] in_byte,
    input  logic       consume,
    output logic       emit,
    output grp_t       grp
);

    localparam logic [1:0] MODE_IDLE = 2'd0;
    localparam logic [1:0] MODE_STR  = 2'd1;
    localparam logic [1:0] MODE_ESC  = 2'd2;
    localparam logic [1:0] MODE_HEX  = 2'd3;

    logic [1:0]  mode_reg, mode_next;
    logic [1:0]  hex_count_reg, hex_count_next;
    logic [15:0] code_point_reg, code_point_next;

    logic        hex_ok;
    logic [3:0]  hex_digit;
    logic [15:0] cp_shift;

    always_comb begin
        hex_ok    = 1'b1;
        hex_digit = 4'd0;
        if (in_byte >= 8'h30 && in_byte <= 8'h39) begin
            hex_digit = in_byte[3:0];
        end else if ((in_byte >= 8'h61 && in_byte <= 8'h66) ||
                     (in_byte >= 8'h41 && in_byte <= 8'h46)) begin
            hex_digit = 4'(in_byte[2:0] + 3'd1) + 4'd8;
        end else begin
            hex_ok = 1'b0;
        end
        cp_shift = {code_point_reg[11:0], hex_digit};
    end

    always_comb begin
        mode_next       = mode_reg;
        hex_count_next  = hex_count_reg;
        code_point_next = code_point_reg;
        emit            = 1'b0;
        grp             = '0;
        case (mode_reg)
            MODE_IDLE: begin
                if (in_byte == 8'h22) begin
                    mode_next       = MODE_STR;
                    hex_count_next  = 2'd0;
                    code_point_next = 16'd0;
                end else begin
                    emit     = 1'b1;
                    grp.kind = KIND_NOQ;
                end
            end
            MODE_STR: begin
                if (in_byte == 8'h00) begin
                    emit     = 1'b1;
                    grp.kind = KIND_UNTER;
                end else if (in_byte == 8'h22) begin
                    emit     = 1'b1;
                    grp.kind = KIND_DONE;
                end else if (in_byte == 8'h5C) begin
                    mode_next = MODE_ESC;
                end else if (in_byte < 8'h20) begin
                    emit     = 1'b1;
                    grp.kind = KIND_CTRL;
                end else begin
                    emit         = 1'b1;
                    grp.kind     = KIND_DATA;
                    grp.bytes[0] = in_byte;
                end
            end
            MODE_ESC: begin
                emit      = 1'b1;
                grp.kind  = KIND_DATA;
                mode_next = MODE_STR;
                case (in_byte)
                    8'h6E: grp.bytes[0] = 8'h0A;    // n
                    8'h74: grp.bytes[0] = 8'h09;    // t
                    8'h72: grp.bytes[0] = 8'h0D;    // r
                    8'h62: grp.bytes[0] = 8'h08;    // b
                    8'h66: grp.bytes[0] = 8'h0C;    // f
                    8'h22, 8'h2F, 8'h5C: grp.bytes[0] = in_byte;
                    8'h75: begin                    // u
                        emit            = 1'b0;
                        mode_next       = MODE_HEX;
                        hex_count_next  = 2'd0;
                        code_point_next = 16'd0;
                    end
                    default: begin
                        grp.kind  = KIND_BADE;
                        mode_next = MODE_IDLE;
                    end
                endcase
            end
            default: begin
                if (!hex_ok) begin
                    emit     = 1'b1;
                    grp.kind = KIND_BADH;
                end else if (hex_count_reg == 2'd3) begin
                    emit            = 1'b1;
                    grp.kind        = KIND_DATA;
                    mode_next       = MODE_STR;
                    hex_count_next  = 2'd0;
                    code_point_next = 16'd0;
                    // UTF-8 encoding of the completed code point.
                    if (cp_shift < 16'h0080) begin
                        grp.bytes[0] = cp_shift[7:0];
                        grp.last_idx = 2'd0;
                    end else if (cp_shift < 16'h0800) begin
                        grp.bytes[0] = {3'b110, cp_shift[10:6]};
                        grp.bytes[1] = {2'b10, cp_shift[5:0]};
                        grp.last_idx = 2'd1;
                    end else begin
                        grp.bytes[0] = {4'b1110, cp_shift[15:12]};
                        grp.bytes[1] = {2'b10, cp_shift[11:6]};
                        grp.bytes[2] = {2'b10, cp_shift[5:0]};
                        grp.last_idx = 2'd2;
                    end
                end else begin
                    hex_count_next  = hex_count_reg + 2'd1;
                    code_point_next = cp_shift;
                end
            end
        endcase
        // Every error and done sends the decoder back to idle.
        if (emit && grp.kind != KIND_DATA) begin
            mode_next       = MODE_IDLE;
            hex_count_next  = 2'd0;
            code_point_next = 16'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg       <= MODE_IDLE;
            hex_count_reg  <= 2'd0;
            code_point_reg <= 16'd0;
        end else if (consume) begin
            mode_reg       <= mode_next;
            hex_count_reg  <= hex_count_next;
            code_point_reg <= code_point_next;
        end
    end

endmodule

// ===== rtl/jsunesc_burst.sv =====
module jsunesc_burst import jsunesc_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       load,
    input  grp_t       grp,
    output logic       free,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic [2:0] m_kind,
    output logic       m_last
);

    logic       valid_reg;
    grp_t       grp_reg;
    logic [1:0] idx_reg;

    assign m_valid    = valid_reg;
    assign m_out_byte = grp_reg.bytes[idx_reg];
    assign m_kind     = grp_reg.kind;
    assign m_last     = (idx_reg == grp_reg.last_idx);

    // The register can take a new group when empty or when its final beat leaves now.
    assign free = !valid_reg || (m_ready && m_last);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end else if (load) begin
            valid_reg <= 1'b1;
            idx_reg   <= 2'd0;
        end else if (valid_reg && m_ready) begin
            if (m_last) begin
                valid_reg <= 1'b0;
            end else begin
                idx_reg <= idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            grp_reg <= grp;
        end
    end

endmodule

// ===== rtl/json_string_unescaper.sv =====
// Path: an accepted byte waits in the input register, is decoded and goes to the output
// register, which shows its first result beat. Throughput: one input byte per cycle while
// the receiver keeps ready high; a byte with a single result or none keeps full rate. A
// finished \u escape that encodes to two or three bytes keeps the output register busy, one
// beat per cycle while ready is high; the next byte with a result waits in the input register.
// Reset: synchronous, active low; it empties both registers and returns the decoder to idle.
module json_string_unescaper import jsunesc_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic [2:0] m_kind,
    output logic       m_last
);

    // Input register: holds one accepted beat until the decoder can use it.
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;

    logic consume;
    logic emit;
    logic free;
    grp_t grp;

    // A byte that yields no result never waits for the output register; one that
    // yields results waits until that register is empty or releasing its last beat.
    assign consume = in_valid_reg && (free || !emit);

    // The input register refills in the same cycle that its byte is decoded.
    assign s_ready = !in_valid_reg || consume;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (consume) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_in_byte;
        end
    end

    // Decoder: string state and the single-pass decode of one byte into a result group.
    jsunesc_decode u_decode (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_byte (in_byte_reg),
        .consume (consume),
        .emit    (emit),
        .grp     (grp)
    );

    // Output register: sends the group one beat per cycle while m_ready is high, marking the final beat.
    jsunesc_burst u_burst (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (consume && emit),
        .grp        (grp),
        .free       (free),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_byte (m_out_byte),
        .m_kind     (m_kind),
        .m_last     (m_last)
    );

endmodule

// ===== dv/json_string_unescaper_tb.sv =====
module json_string_unescaper_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import jsunesc_pkg::*;

    // Characters that steer the decoder. The escape letters that map to a
    // single byte are kept in one table so that the stimulus can pick among
    // them and also avoid them when it builds a bad escape.
    localparam logic [7:0] END_OF_TEXT  = 8'h00;
    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_SLASH     = 8'h2F;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_U         = "u";
    localparam logic [7:0] CTRL_LIMIT   = 8'h20;
    localparam logic [7:0] ESC_LETTERS [8] = '{CH_QUOTE, CH_BACKSLASH, CH_SLASH,
                                               "b", "f", "n", "r", "t"};

    // Decoder state as the predictor tracks it.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_STRING,
        ST_ESCAPE,
        ST_HEX
    } scan_mode_t;

    // One result beat as the block should present it.
    typedef struct {
        logic [7:0] out_byte;
        logic [2:0] kind;
        logic       last;
    } decoded_t;

    logic       aclk      = 1'b0;
    logic       aresetn   = 1'b0;
    logic       s_valid   = 1'b0;
    logic       s_ready;
    logic [7:0] s_in_byte = 8'h00;
    logic       m_valid;
    logic       m_ready   = 1'b0;
    logic [7:0] m_out_byte;
    logic [2:0] m_kind;
    logic       m_last;

    // Predictor state and the store of beats still owed by the block.
    scan_mode_t  scan_mode = ST_IDLE;
    logic [1:0]  hex_seen  = 2'd0;
    logic [15:0] code_acc  = 16'h0000;
    decoded_t    decoded_q[$];

    int unsigned mismatch_count = 0;
    int unsigned bytes_accepted = 0;

    // Idling knobs, in percent of cycles. The sender inserts gaps before a
    // byte, the receiver drops ready on a cycle.
    int unsigned gap_pct   = 0;
    int unsigned stall_pct = 0;

    json_string_unescaper u_dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_in_byte  (s_in_byte),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_byte (m_out_byte),
        .m_kind     (m_kind),
        .m_last     (m_last)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic int hex_digit_value(logic [7:0] c);
        if (c >= "0" && c <= "9") return int'(c - "0");
        if (c >= "a" && c <= "f") return int'(c - "a") + 10;
        if (c >= "A" && c <= "F") return int'(c - "A") + 10;
        return -1;
    endfunction

    function automatic void push_beat(logic [7:0] b, logic [2:0] k, logic l);
        decoded_t beat;
        beat.out_byte = b;
        beat.kind     = k;
        beat.last     = l;
        decoded_q.push_back(beat);
    endfunction

    // Done and every error leave a single beat with a zero byte and drop the
    // decoder back to idle, throwing away any partial code point.
    function automatic void close_string(logic [2:0] k);
        scan_mode = ST_IDLE;
        hex_seen  = 2'd0;
        code_acc  = 16'h0000;
        push_beat(8'h00, k, 1'b1);
    endfunction

    // UTF-8 encoding of a 16-bit code point: one, two or three bytes, with
    // last set only on the final byte. Surrogate halves are encoded as they
    // stand, without pairing.
    function automatic void emit_code_point(logic [15:0] cp);
        if (cp < 16'h0080) begin
            push_beat(cp[7:0], KIND_DATA, 1'b1);
        end else if (cp < 16'h0800) begin
            push_beat({3'b110, cp[10:6]}, KIND_DATA, 1'b0);
            push_beat({2'b10, cp[5:0]}, KIND_DATA, 1'b1);
        end else begin
            push_beat({4'b1110, cp[15:12]}, KIND_DATA, 1'b0);
            push_beat({2'b10, cp[11:6]}, KIND_DATA, 1'b0);
            push_beat({2'b10, cp[5:0]}, KIND_DATA, 1'b1);
        end
    endfunction

    // Works out the beats caused by one accepted text byte and advances the
    // predicted decoder state.
    function automatic void decode_byte(logic [7:0] c);
        int          digit;
        logic [7:0]  esc_val;
        bit          esc_known;
        logic [15:0] cp;
        digit     = hex_digit_value(c);
        esc_known = 1'b1;
        esc_val   = c;
        case (scan_mode)
            ST_IDLE: begin
                if (c == CH_QUOTE) begin
                    scan_mode = ST_STRING;
                    hex_seen  = 2'd0;
                    code_acc  = 16'h0000;
                end else begin
                    close_string(KIND_NOQ);
                end
            end
            ST_STRING: begin
                if (c == END_OF_TEXT) close_string(KIND_UNTER);
                else if (c == CH_QUOTE) close_string(KIND_DONE);
                else if (c == CH_BACKSLASH) scan_mode = ST_ESCAPE;
                else if (c < CTRL_LIMIT) close_string(KIND_CTRL);
                else push_beat(c, KIND_DATA, 1'b1);
            end
            ST_ESCAPE: begin
                case (c)
                    "n":                              esc_val = 8'h0A;
                    "t":                              esc_val = 8'h09;
                    "r":                              esc_val = 8'h0D;
                    "b":                              esc_val = 8'h08;
                    "f":                              esc_val = 8'h0C;
                    CH_QUOTE, CH_SLASH, CH_BACKSLASH: esc_val = c;
                    default:                          esc_known = 1'b0;
                endcase
                if (c == CH_U) begin
                    scan_mode = ST_HEX;
                    hex_seen  = 2'd0;
                    code_acc  = 16'h0000;
                end else if (esc_known) begin
                    scan_mode = ST_STRING;
                    push_beat(esc_val, KIND_DATA, 1'b1);
                end else begin
                    close_string(KIND_BADE);
                end
            end
            default: begin
                if (digit < 0) begin
                    close_string(KIND_BADH);
                end else begin
                    code_acc = {code_acc[11:0], 4'(digit)};
                    if (hex_seen == 2'd3) begin
                        cp        = code_acc;
                        scan_mode = ST_STRING;
                        hex_seen  = 2'd0;
                        code_acc  = 16'h0000;
                        emit_code_point(cp);
                    end else begin
                        hex_seen = hex_seen + 2'd1;
                    end
                end
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Result side: random ready and the per-beat comparison
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what);
        $display("[%0t] beat mismatch: %s", $realtime, what);
        mismatch_count++;
    endtask

    // Ready is redrawn on every cycle after reset. The handshake is judged on
    // the values held just before the edge, so the new ready only matters
    // from the next cycle on.
    always @(posedge aclk) begin : beat_checker
        decoded_t want;
        if (aresetn) begin
            m_ready <= ($urandom_range(99) >= stall_pct);
            if (m_valid && m_ready) begin
                if (decoded_q.size() == 0) begin
                    report_mismatch($sformatf("no beat expected, got byte=%02h kind=%0d last=%0b",
                                              m_out_byte, m_kind, m_last));
                end else begin
                    want = decoded_q.pop_front();
                    if (m_out_byte !== want.out_byte || m_kind !== want.kind ||
                        m_last !== want.last) begin
                        report_mismatch($sformatf(
                            "got byte=%02h kind=%0d last=%0b, want byte=%02h kind=%0d last=%0b",
                            m_out_byte, m_kind, m_last,
                            want.out_byte, want.kind, want.last));
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------

    // Offers one text byte and returns at the edge that accepts it. Valid is
    // left high on return, so a following byte sent at once keeps the input
    // busy with no bubble; gaps only come from the idling knob.
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < gap_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_in_byte <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        bytes_accepted++;
        decode_byte(b);
    endtask

    // Drops valid and holds the input off until every owed beat has been
    // seen, then waits out the given tail so that a stray beat would show.
    task automatic settle(input int unsigned tail);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (decoded_q.size() != 0) @(posedge aclk);
        repeat (tail) @(posedge aclk);
    endtask

    function automatic logic [7:0] hex_char(logic [3:0] n, bit upper);
        if (n < 4'd10) return 8'("0") + 8'(n);
        return (upper ? 8'("A") : 8'("a")) + 8'(n) - 8'd10;
    endfunction

    // A backslash-u escape; each digit is in upper or lower case at random.
    task automatic send_code_point(input logic [15:0] cp);
        send_byte(CH_BACKSLASH);
        send_byte(CH_U);
        for (int i = 3; i >= 0; i--) send_byte(hex_char(cp[i*4 +: 4], $urandom_range(1)));
    endtask

    // One well-formed piece of string content: a printable byte, a byte with
    // the top bit set, a one-letter escape, or a code point escape. Code
    // points are spread evenly over the one, two and three byte encodings.
    task automatic send_content();
        int unsigned pick;
        logic [7:0]  b;
        pick = $urandom_range(99);
        if (pick < 45) begin
            do b = 8'($urandom_range(32, 126)); while (b == CH_QUOTE || b == CH_BACKSLASH);
            send_byte(b);
        end else if (pick < 60) begin
            send_byte(8'($urandom_range(128, 255)));
        end else if (pick < 80) begin
            send_byte(CH_BACKSLASH);
            send_byte(ESC_LETTERS[$urandom_range(7)]);
        end else begin
            case ($urandom_range(2))
                0:       send_code_point(16'($urandom_range(0, 16'h007F)));
                1:       send_code_point(16'($urandom_range(16'h0080, 16'h07FF)));
                default: send_code_point(16'($urandom_range(16'h0800, 16'hFFFF)));
            endcase
        end
    endtask

    task automatic send_good_string();
        send_byte(CH_QUOTE);
        repeat ($urandom_range(0, 10)) send_content();
        send_byte(CH_QUOTE);
    endtask

    // A string that goes wrong after a little valid content. The last flavor
    // simply stops, so the string stays open and whatever follows lands in it.
    task automatic send_broken_string();
        logic [7:0] b;
        bit         is_letter;
        send_byte(CH_QUOTE);
        repeat ($urandom_range(0, 4)) send_content();
        case ($urandom_range(4))
            0: send_byte(8'($urandom_range(1, 31)));
            1: begin
                do begin
                    b         = 8'($urandom_range(255));
                    is_letter = (b == CH_U);
                    foreach (ESC_LETTERS[i]) if (b == ESC_LETTERS[i]) is_letter = 1'b1;
                end while (is_letter);
                send_byte(CH_BACKSLASH);
                send_byte(b);
            end
            2: begin
                send_byte(CH_BACKSLASH);
                send_byte(CH_U);
                repeat ($urandom_range(0, 3)) send_byte(hex_char(4'($urandom), $urandom_range(1)));
                do b = 8'($urandom_range(255)); while (hex_digit_value(b) >= 0);
                send_byte(b);
            end
            3: send_byte(END_OF_TEXT);
            default: ;
        endcase
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Outside a string every byte but a quote is refused, end of text too;
    // an empty string closes at once.
    task automatic test_outside_string();
        send_byte("x");
        send_byte(END_OF_TEXT);
        send_byte(CH_QUOTE);
        send_byte(CH_QUOTE);
        settle(4);
    endtask

    // Bytes from the space up, delete and the top-bit range included, pass
    // through; a control byte ends the string with an error.
    task automatic test_plain_bytes();
        send_byte(CH_QUOTE);
        send_byte(8'hFF);
        send_byte(8'h7F);
        send_byte(CTRL_LIMIT);
        send_byte(CTRL_LIMIT - 8'd1);
        settle(4);
    endtask

    // The smallest code point, the largest two-byte one and the largest of
    // all, which needs the full three-byte burst.
    task automatic test_code_points();
        send_byte(CH_QUOTE);
        send_code_point(16'h0000);
        send_code_point(16'h07FF);
        send_code_point(16'hFFFF);
        send_byte(CH_QUOTE);
        settle(4);
    endtask

    // End of text after a backslash, end of text among hex digits, end of
    // text in plain content, and an unknown escape letter.
    task automatic test_error_exits();
        send_byte(CH_QUOTE);
        send_byte(CH_BACKSLASH);
        send_byte(END_OF_TEXT);
        send_byte(CH_QUOTE);
        send_byte(CH_BACKSLASH);
        send_byte(CH_U);
        send_byte("a");
        send_byte(END_OF_TEXT);
        send_byte(CH_QUOTE);
        send_byte(END_OF_TEXT);
        send_byte(CH_QUOTE);
        send_byte(CH_BACKSLASH);
        send_byte("q");
        settle(4);
    endtask

    // Random text under one idling setting: mostly well-formed strings,
    // some broken ones, and now and then a loose byte. Each phase ends with
    // the input held off until the block has caught up.
    task automatic test_random_text(input int unsigned gap, input int unsigned stall,
                                    input int unsigned budget);
        int unsigned start;
        int unsigned pick;
        gap_pct   = gap;
        stall_pct = stall;
        start     = bytes_accepted;
        while (bytes_accepted - start < budget) begin
            pick = $urandom_range(99);
            if (pick < 72) send_good_string();
            else if (pick < 92) send_broken_string();
            else send_byte(8'($urandom_range(255)));
        end
        settle(6);
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_outside_string();
        test_plain_bytes();
        test_code_points();
        test_error_exits();

        test_random_text(0, 0, 64);
        test_random_text(52, 0, 64);
        test_random_text(0, 52, 64);
        test_random_text(31, 31, 64);

        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // This bound is far beyond the slowest correct run of this size and
    // only catches a hung handshake.
    initial begin
        #400_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/jsunesc_pkg.sv
rtl/jsunesc_decode.sv
rtl/jsunesc_burst.sv
rtl/json_string_unescaper.sv
dv/json_string_unescaper_tb.sv
